>>> hw/rtl/slrc_pkg.sv
// Shared types and constants for the stereo left-right consistency check.
`default_nettype none

package slrc_pkg;

    // Default parameter values
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int DISP_BITS_DEF = 8;

    // Fixed field widths of the stream words
    localparam int COL_W     = 10;
    localparam int ROW_W     = 10;
    localparam int IN_DISP_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 11;
    localparam int BCOL_W     = 10;
    localparam int BROW_W     = 10;
    localparam int THR_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_COLUMNS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_ROWS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 3'd4;

    // Configuration reset values
    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST     = 11'd640;
    localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST    = 11'd480;
    localparam logic [BCOL_W-1:0]   BORDER_COLUMNS_RST  = 10'd0;
    localparam logic [BROW_W-1:0]   BORDER_ROWS_RST     = 10'd0;
    localparam logic [THR_W-1:0]    MATCH_THRESHOLD_RST = 8'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_we;      // write both disparities at the column
        logic check_start;  // capture column, border test, read stores at column
        logic pred_rd;      // read stores at the predicted columns
        logic result_ld;    // load the flags into the output register
    } t_cmd;

endpackage

`default_nettype wire

>>> hw/rtl/stereo_left_right_check_top.sv
// Loads: one word per cycle while no check is in progress, taken in the cycle it arrives,
// no result word. Checks: a new word waits for the two dependent reads of each row store
// (at the column, then at the predicted columns) and the output register load.
// The next word is taken while a result waits; a check behind it holds until that is taken.
// Reset (synchronous, active low) clears control state and configuration;
// the row stores are not cleared and read undefined until written.
`default_nettype none

module stereo_left_right_check_top
    import slrc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int DISP_BITS = DISP_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [39:0]           s_axis_tdata,  // column, row, left_disparity, right_disparity
    input  wire  [0:0]            s_axis_tuser,  // mode
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // left_valid, right_valid
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    logic left_valid, right_valid;

    // Unpack the input word
    logic [COL_W-1:0]           column;
    logic [ROW_W-1:0]           row;
    logic signed [IN_DISP_W-1:0] left_disparity, right_disparity;

    assign column          = s_axis_tdata[9:0];
    assign row             = s_axis_tdata[19:10];
    assign left_disparity  = signed'(s_axis_tdata[27:20]);
    assign right_disparity = signed'(s_axis_tdata[35:28]);

    slrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    slrc_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .DISP_BITS (DISP_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (cmd),
        .i_column          (column),
        .i_row             (row),
        .i_left_disparity  (left_disparity),
        .i_right_disparity (right_disparity),
        .o_left_valid      (left_valid),
        .o_right_valid     (right_valid)
    );

    // Pack the result word
    assign m_axis_tdata = {6'd0, right_valid, left_valid};

endmodule

`default_nettype wire

>>> hw/rtl/slrc_ctrl.sv
// Controller state machine: sequences loads and the two read phases of a check.
`default_nettype none

module slrc_ctrl
    import slrc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_in_mode,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_RD_COL   = 3'b010,
        ST_RD_PRED  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // Decide next state and issue commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_mode) begin
                        o_cmd.check_start = 1'b1;
                        n_state           = ST_RD_COL;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            ST_RD_COL: begin
                o_cmd.pred_rd = 1'b1;
                n_state       = ST_RD_PRED;
            end
            ST_RD_PRED: begin
                // hold until the output register can take the word
                if (out_free) begin
                    o_cmd.result_ld = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.result_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/slrc_datapath.sv
// Datapath: configuration registers, row stores, border test and match compare.
`default_nettype none

module slrc_datapath
    import slrc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int DISP_BITS = DISP_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]      i_cfg_wdata,
    input  t_cmd                       i_cmd,
    input  wire  [COL_W-1:0]           i_column,
    input  wire  [ROW_W-1:0]           i_row,
    input  wire  signed [IN_DISP_W-1:0] i_left_disparity,
    input  wire  signed [IN_DISP_W-1:0] i_right_disparity,
    output logic                       o_left_valid,
    output logic                       o_right_valid
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int AXW = AW + COL_W;
    localparam int PW  = ((DISP_BITS > 14) ? DISP_BITS : 14) + 2;
    localparam int DW  = DISP_BITS + 1;
    localparam int CW  = (DW > THR_W) ? DW : THR_W;
    localparam int BW  = 13;
    localparam logic signed [PW-1:0] MAXW_P = PW'(MAX_WIDTH);

    // Configuration registers
    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [BCOL_W-1:0]   r_border_columns;
    logic [BROW_W-1:0]   r_border_rows;
    logic [THR_W-1:0]    r_match_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= IMAGE_WIDTH_RST;
            r_image_height    <= IMAGE_HEIGHT_RST;
            r_border_columns  <= BORDER_COLUMNS_RST;
            r_border_rows     <= BORDER_ROWS_RST;
            r_match_threshold <= MATCH_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_wdata[HEIGHT_W-1:0];
                CFG_BORDER_COLUMNS:  r_border_columns  <= i_cfg_wdata[BCOL_W-1:0];
                CFG_BORDER_ROWS:     r_border_rows     <= i_cfg_wdata[BROW_W-1:0];
                CFG_MATCH_THRESHOLD: r_match_threshold <= i_cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Column address and store range test
    logic [AXW-1:0] col_ext;
    logic [AW-1:0]  col_addr;
    logic           col_in_store;

    assign col_ext      = AXW'(i_column);
    assign col_addr     = col_ext[AW-1:0];
    assign col_in_store = (32'(i_column) < MAX_WIDTH);

    // Border test on the incoming check word
    logic signed [BW-1:0] col_s, row_s, col_lim, row_lim;
    logic                 in_frame;

    assign col_s    = signed'(BW'(i_column));
    assign row_s    = signed'(BW'(i_row));
    assign col_lim  = signed'(BW'(r_image_width)) - signed'(BW'(r_border_columns));
    assign row_lim  = signed'(BW'(r_image_height)) - signed'(BW'(r_border_rows));
    assign in_frame = (col_s >= signed'(BW'(r_border_columns))) && (col_s < col_lim) &&
                      (row_s >= signed'(BW'(r_border_rows))) && (row_s < row_lim) &&
                      col_in_store;

    logic [COL_W-1:0] r_col;
    logic             r_inside;

    always_ff @(posedge i_clk) begin
        if (i_cmd.check_start) begin
            r_col    <= i_column;
            r_inside <= in_frame;
        end
    end

    // Row stores
    logic [DISP_BITS-1:0] r_left_mem  [MAX_WIDTH];
    logic [DISP_BITS-1:0] r_right_mem [MAX_WIDTH];
    logic signed [DISP_BITS-1:0] r_left_q, r_right_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && col_in_store) begin
            r_left_mem[col_addr]  <= DISP_BITS'(i_left_disparity);
            r_right_mem[col_addr] <= DISP_BITS'(i_right_disparity);
        end
    end

    // Predicted columns from the column reads
    logic signed [PW-1:0] col_p, p_col, q_col, width_p;
    logic                 p_ok, q_ok;

    assign col_p   = signed'(PW'(r_col));
    assign p_col   = col_p - PW'(r_left_q);
    assign q_col   = col_p + PW'(r_right_q);
    assign width_p = signed'(PW'(r_image_width));
    assign p_ok    = (p_col >= 0) && (p_col < width_p) && (p_col < MAXW_P);
    assign q_ok    = (q_col >= 0) && (q_col < width_p) && (q_col < MAXW_P);

    // Read left at column then q, right at column then p
    logic [AW-1:0] left_rd_addr, right_rd_addr;
    logic          rd_en;

    assign rd_en         = i_cmd.check_start || i_cmd.pred_rd;
    assign left_rd_addr  = i_cmd.check_start ? col_addr : q_col[AW-1:0];
    assign right_rd_addr = i_cmd.check_start ? col_addr : p_col[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_left_q  <= r_left_mem[left_rd_addr];
            r_right_q <= r_right_mem[right_rd_addr];
        end
    end

    // Keep own disparities and range results for the compare phase
    logic signed [DISP_BITS-1:0] r_left_own, r_right_own;
    logic                        r_p_ok, r_q_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pred_rd) begin
            r_left_own  <= r_left_q;
            r_right_own <= r_right_q;
            r_p_ok      <= p_ok;
            r_q_ok      <= q_ok;
        end
    end

    // Compare absolute differences against the threshold
    logic signed [DW-1:0] diff_l, diff_r;
    logic [DW-1:0]        abs_l, abs_r;
    logic                 match_l, match_r;

    assign diff_l  = DW'(r_right_q) - DW'(r_left_own);
    assign diff_r  = DW'(r_left_q) - DW'(r_right_own);
    assign abs_l   = diff_l[DW-1] ? unsigned'(-diff_l) : unsigned'(diff_l);
    assign abs_r   = diff_r[DW-1] ? unsigned'(-diff_r) : unsigned'(diff_r);
    assign match_l = (CW'(abs_l) < CW'(r_match_threshold));
    assign match_r = (CW'(abs_r) < CW'(r_match_threshold));

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.result_ld) begin
            o_left_valid  <= r_inside && r_p_ok && match_l;
            o_right_valid <= r_inside && r_q_ok && match_r;
        end
    end

endmodule

`default_nettype wire

>>> sim/stereo_left_right_check_top_test.sv
// Self-checking testbench for the stereo left-right consistency check block.
`timescale 1ns / 100ps

module stereo_left_right_check_top_test;
    import slrc_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH_DEF;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_CHECK = 1'b1
    } t_mode;

    // Input word layout, column in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] right_disparity;
        logic [7:0] left_disparity;
        logic [9:0] row;
        logic [9:0] column;
    } t_pixel_word;

    typedef struct packed {
        logic right_ok;
        logic left_ok;
    } t_flags;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;   // column, row, left_disparity, right_disparity
    logic [0:0]            s_axis_tuser;   // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // left_valid, right_valid
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Shadow of the block's configuration and row stores
    int cfg_width;
    int cfg_height;
    int cfg_bcol;
    int cfg_brow;
    int cfg_thr;
    logic signed [7:0] left_disp_row [STORE_DEPTH];
    logic signed [7:0] right_disp_row [STORE_DEPTH];
    bit                column_loaded [STORE_DEPTH];

    t_flags pending_flags [$];
    int     fail_count;
    int     items_sent;
    int     sender_idle_pct;
    int     receiver_stall_pct;

    stereo_left_right_check_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int disparity_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Work out both flags of a check word from the shadow stores
    function automatic t_flags predict_flags(input int col, input int row);
        t_flags f;
        int     ld;
        int     rd;
        int     lpos;
        int     rpos;
        f = '0;
        if (col >= cfg_bcol && col < cfg_width - cfg_bcol &&
            row >= cfg_brow && row < cfg_height - cfg_brow) begin
            ld   = int'(left_disp_row[col]);
            rd   = int'(right_disp_row[col]);
            lpos = col - ld;
            rpos = col + rd;
            if (lpos >= 0 && lpos < cfg_width && lpos < STORE_DEPTH)
                f.left_ok = disparity_gap(int'(right_disp_row[lpos]), ld) < cfg_thr;
            if (rpos >= 0 && rpos < cfg_width && rpos < STORE_DEPTH)
                f.right_ok = disparity_gap(int'(left_disp_row[rpos]), rd) < cfg_thr;
        end
        return f;
    endfunction

    function automatic t_pixel_word make_word(input int col, input int row,
                                              input int ld, input int rd);
        t_pixel_word w;
        w                 = '0;
        w.column          = col[9:0];
        w.row             = row[9:0];
        w.left_disparity  = ld[7:0];
        w.right_disparity = rd[7:0];
        return w;
    endfunction

    // Send one word; called and returns just after a falling edge
    task automatic send_word(input t_mode mode, input t_pixel_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        if (mode == MODE_LOAD) begin
            left_disp_row[w.column]  = w.left_disparity;
            right_disp_row[w.column] = w.right_disparity;
            column_loaded[w.column]  = 1'b1;
        end else begin
            pending_flags.push_back(predict_flags(int'(w.column), int'(w.row)));
        end
        @(negedge i_clk);
    endtask

    // Load both disparities at a column; drop columns outside the store
    task automatic load_pixel(input int col, input int ld, input int rd);
        if (col >= 0 && col < STORE_DEPTH)
            send_word(MODE_LOAD, make_word(col, $urandom_range(1023), ld, rd));
    endtask

    // Check a column, first filling any store entry the check could read
    task automatic check_pixel(input int col, input int row);
        int lpos;
        int rpos;
        if (!column_loaded[col])
            load_pixel(col, $urandom_range(255), $urandom_range(255));
        lpos = (col - int'(left_disp_row[col])) & (STORE_DEPTH - 1);
        if (!column_loaded[lpos])
            load_pixel(lpos, $urandom_range(255), $urandom_range(255));
        rpos = (col + int'(right_disp_row[col])) & (STORE_DEPTH - 1);
        if (!column_loaded[rpos])
            load_pixel(rpos, $urandom_range(255), $urandom_range(255));
        send_word(MODE_CHECK, make_word(col, row, $urandom_range(255), $urandom_range(255)));
    endtask

    // Hold the sender until every result is back, then let the pipeline settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_flags.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write all five registers; the block must be idle
    task automatic apply_config(input int width, input int height, input int bcol,
                                input int brow, input int thr);
        logic [CFG_IDX_W-1:0] reg_index [5];
        int                   reg_value [5];
        reg_index = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_BORDER_COLUMNS,
                      CFG_BORDER_ROWS, CFG_MATCH_THRESHOLD};
        reg_value = '{width, height, bcol, brow, thr};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_index[i];
            i_cfg_wdata <= reg_value[i][CFG_DATA_W-1:0];
            @(negedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cfg_width  = width;
        cfg_height = height;
        cfg_bcol   = bcol;
        cfg_brow   = brow;
        cfg_thr    = thr;
    endtask

    // Default configuration: image edges, negative and beyond-width predictions
    task automatic test_directed_cases();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        load_pixel(0, 0, 0);
        check_pixel(0, 0);
        load_pixel(1023, -128, 127);
        check_pixel(1023, 1023);
        // predicted column equal to the width lies outside the image
        load_pixel(639, 0, -10);
        load_pixel(629, -10, 10);
        check_pixel(629, 0);
        load_pixel(630, -10, 10);
        check_pixel(630, 5);
        // predictions left of column zero
        load_pixel(3, 5, -7);
        check_pixel(3, 0);
        // difference just below and equal to the threshold
        load_pixel(98, 7, 3);
        load_pixel(100, 2, 0);
        check_pixel(100, 479);
        check_pixel(100, 480);
        load_pixel(200, 127, -128);
        check_pixel(200, 10);
        drain_results();
    endtask

    // Widest image and loosest threshold; predictions past the store end
    task automatic test_wide_image();
        apply_config(1024, 1024, 0, 0, 255);
        load_pixel(1023, -1, 1);
        check_pixel(1023, 1023);
        load_pixel(1022, 5, -5);
        check_pixel(1022, 0);
        for (int i = 0; i < 8; i++)
            check_pixel($urandom_range(1023), $urandom_range(1023));
        drain_results();
    endtask

    // One-pixel image
    task automatic test_single_pixel_image();
        apply_config(1, 1, 0, 0, 8);
        load_pixel(0, 0, 0);
        check_pixel(0, 0);
        check_pixel(0, 1);
        check_pixel(1, 0);
        drain_results();
    endtask

    // Borders: all-excluding and a narrow frame tested at its edges
    task automatic test_borders();
        apply_config(1024, 1024, 512, 512, 2);
        check_pixel(511, 511);
        check_pixel(512, 512);
        check_pixel(0, 0);
        drain_results();
        apply_config(200, 100, 10, 20, 4);
        load_pixel(10, 0, 0);
        load_pixel(189, 0, 0);
        check_pixel(10, 20);
        check_pixel(9, 20);
        check_pixel(189, 79);
        check_pixel(190, 79);
        check_pixel(189, 80);
        drain_results();
    endtask

    // Zero threshold rejects every pixel
    task automatic test_threshold_zero();
        apply_config(640, 480, 0, 0, 0);
        load_pixel(50, 0, 0);
        check_pixel(50, 5);
        drain_results();
    endtask

    function automatic int pick_column();
        if ($urandom_range(7) == 0)
            return $urandom_range(1023);
        return $urandom_range((cfg_width > 1023) ? 1023 : cfg_width);
    endfunction

    function automatic int pick_row();
        if ($urandom_range(7) == 0)
            return $urandom_range(1023);
        return $urandom_range((cfg_height > 1023) ? 1023 : cfg_height);
    endfunction

    function automatic int pick_disparity();
        if ($urandom_range(9) == 0)
            return int'($urandom_range(255)) - 128;
        return int'($urandom_range(24)) - 12;
    endfunction

    // Mostly matching disparity pairs with a check, plus noise loads and stray checks
    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
        int start_count;
        int pick;
        int c;
        int d;
        int e;
        int w;
        int h;
        drain_results();
        w = $urandom_range(16, 1024);
        h = $urandom_range(1, 1024);
        apply_config(w, h, $urandom_range(w / 8), $urandom_range(h / 8), $urandom_range(1, 16));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start_count        = items_sent;
        while (items_sent - start_count < count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                c = $urandom_range(cfg_width - 1);
                d = pick_disparity();
                e = pick_disparity();
                load_pixel(c + e, e + int'($urandom_range(6)) - 3, pick_disparity());
                load_pixel(c - d, pick_disparity(), d + int'($urandom_range(6)) - 3);
                load_pixel(c, d, e);
                check_pixel(c, pick_row());
            end else if (pick < 60) begin
                load_pixel($urandom_range(1023), $urandom_range(255), $urandom_range(255));
            end else begin
                check_pixel(pick_column(), pick_row());
            end
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 350);
        run_random_phase(50, 0, 350);
        run_random_phase(0, 50, 350);
        run_random_phase(9, 9, 350);
    endtask

    // Randomise the result side ready
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each result word against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_flags want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_flags.size() == 0) begin
                $error("unexpected result word: left_valid=%0d right_valid=%0d",
                       m_axis_tdata[0], m_axis_tdata[1]);
                fail_count++;
            end else begin
                want = pending_flags.pop_front();
                if (m_axis_tdata[0] !== want.left_ok) begin
                    $error("left_valid: expected %0d, actual %0d", want.left_ok, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[1] !== want.right_ok) begin
                    $error("right_valid: expected %0d, actual %0d", want.right_ok, m_axis_tdata[1]);
                    fail_count++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        s_axis_tuser       = '0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_wdata        = '0;
        fail_count         = 0;
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        cfg_width          = int'(IMAGE_WIDTH_RST);
        cfg_height         = int'(IMAGE_HEIGHT_RST);
        cfg_bcol           = int'(BORDER_COLUMNS_RST);
        cfg_brow           = int'(BORDER_ROWS_RST);
        cfg_thr            = int'(MATCH_THRESHOLD_RST);
        for (int i = 0; i < STORE_DEPTH; i++) begin
            left_disp_row[i]  = '0;
            right_disp_row[i] = '0;
            column_loaded[i]  = 1'b0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_wide_image();
        test_single_pixel_image();
        test_borders();
        test_threshold_zero();
        test_random_traffic();

        drain_results();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
